// ===== rtl/core/rpsm_pkg.sv =====
// shared types and constants of the raid5 partial stripe mapper
`default_nettype none
package rpsm_pkg;

   localparam int ADDR_W    = 48;
   localparam int COUNT_W   = 32;
   localparam int STRIP_W   = 17;
   localparam int DISKS_W   = 7;
   localparam int CHUNK_W   = 6;
   localparam int DEV_W     = 49;
   localparam int BMAP_W    = 63;
   localparam int STATUS_W  = 2;
   localparam int MAX_DISKS = 64;
   localparam int MIN_DISKS = 3;

   // shared divider sizes
   localparam int DIVD_W = 48;
   localparam int DIVS_W = 23;
   localparam int STEP_W = 6;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 128;
   localparam int RSP_USER_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_STRIP_BLOCKS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_COUNT       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_START_BLOCK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISALIGNED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_COUNT  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STRIPE_SIZE,
      ST_DIV_STRIPE,
      ST_DIV_FIRST,
      ST_DIV_COUNT,
      ST_CHECK,
      ST_DIV_PARITY,
      ST_DIV_BASE,
      ST_MASK,
      ST_EMIT,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
      logic [DIVS_W-1:0] remainder;
   } div_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/core/raid5_partial_stripe_mapper.sv =====
// top level: maps a partial stripe write request to its member disk accesses
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | req_tdata
//  rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata, rsp_tuser, rsp_tlast
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// one request runs five divisions on the shared one-bit-per-cycle divider, one after the
// other; a good request then offers one result per cycle while rsp_tready is high, one
// per modified chunk and then the parity result, and the next request can transfer once
// the last result is registered; an error request skips the last two divisions and
// offers a single error result. req_tready is high only while idle; while the result
// register is full, rsp_tready low stalls the sequencer, and the result register lets
// the last result wait on rsp_tready while the next request is taken. reset is
// synchronous and restores strip_blocks 128, disk_count 4, data_start_block 0.
`default_nettype none
module raid5_partial_stripe_mapper (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // start_block[47:0], block_count[79:48]
   input  wire  [rpsm_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // disk_index[5:0], device_block[54:6], chunk_number[60:55],
   // modified_map[123:61], zero[127:124]
   output logic [rpsm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // is_parity[0], status[2:1]
   output logic [rpsm_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [rpsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [rpsm_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int CW = rpsm_pkg::CHUNK_W;

   // configuration registers
   logic [rpsm_pkg::STRIP_W-1:0]  cfg_strip_ff;
   logic [rpsm_pkg::DISKS_W-1:0]  cfg_disks_ff;
   logic [rpsm_pkg::ADDR_W-1:0]   cfg_dstart_ff;

   rpsm_pkg::state_type           state_ff, state_in;
   logic                          launched_ff, launched_in;

   logic [rpsm_pkg::ADDR_W-1:0]   start_ff, start_in;
   logic [rpsm_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [rpsm_pkg::STRIP_W-1:0]  strip_ff, strip_in;
   logic [rpsm_pkg::DISKS_W-1:0]  disks_ff, disks_in;
   logic [CW-1:0]                 dc_ff, dc_in;
   logic [rpsm_pkg::DIVS_W-1:0]   sb_ff, sb_in;
   logic [rpsm_pkg::ADDR_W-1:0]   stripe_ff, stripe_in;
   logic [rpsm_pkg::DIVS_W-1:0]   offset_ff, offset_in;
   logic [CW-1:0]                 first_ff, first_in;
   logic [rpsm_pkg::COUNT_W-1:0]  nmod_ff, nmod_in;
   logic                          mis_ff, mis_in;
   logic [CW-1:0]                 pmod_ff, pmod_in;
   logic [CW-1:0]                 parity_ff, parity_in;
   logic [rpsm_pkg::DEV_W-1:0]    dev_ff, dev_in;
   logic [rpsm_pkg::BMAP_W-1:0]   bmap_ff, bmap_in;
   logic [CW-1:0]                 chunk_ff, chunk_in;
   logic [CW-1:0]                 left_ff, left_in;
   logic [rpsm_pkg::STATUS_W-1:0] err_ff, err_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                 o_disk_ff, o_disk_in;
   logic [rpsm_pkg::DEV_W-1:0]    o_dev_ff, o_dev_in;
   logic [CW-1:0]                 o_chunk_ff, o_chunk_in;
   logic                          o_par_ff, o_par_in;
   logic [rpsm_pkg::BMAP_W-1:0]   o_bmap_ff, o_bmap_in;
   logic [rpsm_pkg::STATUS_W-1:0] o_status_ff, o_status_in;
   logic                          o_last_ff, o_last_in;

   rpsm_pkg::div_req_type         div_req;
   rpsm_pkg::div_rsp_type         div_rsp;

   logic                          req_xfer;
   logic                          slot_free;
   logic                          bad_count;
   logic [rpsm_pkg::STRIP_W-1:0]  strip_eff;
   logic [rpsm_pkg::DISKS_W-1:0]  disks_eff;
   logic [rpsm_pkg::DISKS_W-1:0]  dc_wide;
   logic [rpsm_pkg::COUNT_W:0]    span;
   logic [rpsm_pkg::BMAP_W-1:0]   ones;

   rpsm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_strip_ff  <= rpsm_pkg::STRIP_W'(128);
         cfg_disks_ff  <= rpsm_pkg::DISKS_W'(4);
         cfg_dstart_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == rpsm_pkg::CSR_STRIP_BLOCKS) begin
            cfg_strip_ff <= csr_data[rpsm_pkg::STRIP_W-1:0];
         end
         if (csr_index == rpsm_pkg::CSR_DISK_COUNT) begin
            cfg_disks_ff <= csr_data[rpsm_pkg::DISKS_W-1:0];
         end
         if (csr_index == rpsm_pkg::CSR_DATA_START_BLOCK) begin
            cfg_dstart_ff <= csr_data[rpsm_pkg::ADDR_W-1:0];
         end
      end
   end

   assign req_tready = (state_ff == rpsm_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // zero strip size counts as one; disk count clamps to the legal range
   assign strip_eff = (cfg_strip_ff == '0) ? rpsm_pkg::STRIP_W'(1) : cfg_strip_ff;
   always_comb begin
      if (cfg_disks_ff < rpsm_pkg::DISKS_W'(rpsm_pkg::MIN_DISKS)) begin
         disks_eff = rpsm_pkg::DISKS_W'(rpsm_pkg::MIN_DISKS);
      end else if (cfg_disks_ff > rpsm_pkg::DISKS_W'(rpsm_pkg::MAX_DISKS)) begin
         disks_eff = rpsm_pkg::DISKS_W'(rpsm_pkg::MAX_DISKS);
      end else begin
         disks_eff = cfg_disks_ff;
      end
   end
   assign dc_wide = disks_eff - 1'b1;

   assign span = {1'b0, {(rpsm_pkg::COUNT_W-CW){1'b0}}, first_ff} + {1'b0, nmod_ff};
   assign bad_count = (nmod_ff == '0)
                   || (nmod_ff >= {{(rpsm_pkg::COUNT_W-CW){1'b0}}, dc_ff})
                   || (span > {{(rpsm_pkg::COUNT_W-CW+1){1'b0}}, dc_ff});

   assign ones = ~({rpsm_pkg::BMAP_W{1'b1}} << nmod_ff[CW-1:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpsm_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = rpsm_pkg::ST_STRIPE_SIZE;
            end
         end
         rpsm_pkg::ST_STRIPE_SIZE: state_in = rpsm_pkg::ST_DIV_STRIPE;
         rpsm_pkg::ST_DIV_STRIPE: begin
            if (div_rsp.done) begin
               state_in = rpsm_pkg::ST_DIV_FIRST;
            end
         end
         rpsm_pkg::ST_DIV_FIRST: begin
            if (div_rsp.done) begin
               state_in = rpsm_pkg::ST_DIV_COUNT;
            end
         end
         rpsm_pkg::ST_DIV_COUNT: begin
            if (div_rsp.done) begin
               state_in = rpsm_pkg::ST_CHECK;
            end
         end
         rpsm_pkg::ST_CHECK: begin
            if (mis_ff || bad_count) begin
               state_in = rpsm_pkg::ST_ERROR;
            end else begin
               state_in = rpsm_pkg::ST_DIV_PARITY;
            end
         end
         rpsm_pkg::ST_DIV_PARITY: begin
            if (div_rsp.done) begin
               state_in = rpsm_pkg::ST_DIV_BASE;
            end
         end
         rpsm_pkg::ST_DIV_BASE: begin
            if (div_rsp.done) begin
               state_in = rpsm_pkg::ST_MASK;
            end
         end
         rpsm_pkg::ST_MASK: state_in = rpsm_pkg::ST_EMIT;
         rpsm_pkg::ST_EMIT: begin
            if (slot_free && left_ff == '0) begin
               state_in = rpsm_pkg::ST_IDLE;
            end
         end
         rpsm_pkg::ST_ERROR: begin
            if (slot_free) begin
               state_in = rpsm_pkg::ST_IDLE;
            end
         end
         default: state_in = rpsm_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      launched_in = launched_ff;
      start_in    = start_ff;
      count_in    = count_ff;
      strip_in    = strip_ff;
      disks_in    = disks_ff;
      dc_in       = dc_ff;
      sb_in       = sb_ff;
      stripe_in   = stripe_ff;
      offset_in   = offset_ff;
      first_in    = first_ff;
      nmod_in     = nmod_ff;
      mis_in      = mis_ff;
      pmod_in     = pmod_ff;
      parity_in   = parity_ff;
      dev_in      = dev_ff;
      bmap_in     = bmap_ff;
      chunk_in    = chunk_ff;
      left_in     = left_ff;
      err_in      = err_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      o_disk_in    = o_disk_ff;
      o_dev_in     = o_dev_ff;
      o_chunk_in   = o_chunk_ff;
      o_par_in     = o_par_ff;
      o_bmap_in    = o_bmap_ff;
      o_status_in  = o_status_ff;
      o_last_in    = o_last_ff;

      div_req.start    = 1'b0;
      div_req.dividend = start_ff;
      div_req.divisor  = sb_ff;
      div_req.steps    = rpsm_pkg::STEP_W'(rpsm_pkg::ADDR_W);

      case (state_ff)
         rpsm_pkg::ST_IDLE: begin
            if (req_xfer) begin
               start_in = req_tdata[rpsm_pkg::ADDR_W-1:0];
               count_in = req_tdata[rpsm_pkg::ADDR_W +: rpsm_pkg::COUNT_W];
               strip_in = strip_eff;
               disks_in = disks_eff;
               dc_in    = dc_wide[CW-1:0];
               mis_in   = 1'b0;
            end
         end
         rpsm_pkg::ST_STRIPE_SIZE: begin
            sb_in = {{(rpsm_pkg::DIVS_W-rpsm_pkg::STRIP_W){1'b0}}, strip_ff}
                  * {{(rpsm_pkg::DIVS_W-CW){1'b0}}, dc_ff};
         end
         rpsm_pkg::ST_DIV_STRIPE: begin
            div_req.start = !launched_ff;
            launched_in   = 1'b1;
            if (div_rsp.done) begin
               launched_in = 1'b0;
               stripe_in   = div_rsp.quotient;
               offset_in   = div_rsp.remainder;
            end
         end
         rpsm_pkg::ST_DIV_FIRST: begin
            // offset sits in the top bits so only its 23 bits are stepped
            div_req.start    = !launched_ff;
            div_req.dividend = {offset_ff, {(rpsm_pkg::DIVD_W-rpsm_pkg::DIVS_W){1'b0}}};
            div_req.divisor  = {{(rpsm_pkg::DIVS_W-rpsm_pkg::STRIP_W){1'b0}}, strip_ff};
            div_req.steps    = rpsm_pkg::STEP_W'(rpsm_pkg::DIVS_W);
            launched_in      = 1'b1;
            if (div_rsp.done) begin
               launched_in = 1'b0;
               first_in    = div_rsp.quotient[CW-1:0];
               mis_in      = (div_rsp.remainder != '0);
            end
         end
         rpsm_pkg::ST_DIV_COUNT: begin
            div_req.start    = !launched_ff;
            div_req.dividend = {count_ff, {(rpsm_pkg::DIVD_W-rpsm_pkg::COUNT_W){1'b0}}};
            div_req.divisor  = {{(rpsm_pkg::DIVS_W-rpsm_pkg::STRIP_W){1'b0}}, strip_ff};
            div_req.steps    = rpsm_pkg::STEP_W'(rpsm_pkg::COUNT_W);
            launched_in      = 1'b1;
            if (div_rsp.done) begin
               launched_in = 1'b0;
               nmod_in     = div_rsp.quotient[rpsm_pkg::COUNT_W-1:0];
               mis_in      = mis_ff || (div_rsp.remainder != '0);
            end
         end
         rpsm_pkg::ST_CHECK: begin
            err_in = mis_ff ? rpsm_pkg::STATUS_MISALIGNED : rpsm_pkg::STATUS_BAD_COUNT;
         end
         rpsm_pkg::ST_DIV_PARITY: begin
            div_req.start    = !launched_ff;
            div_req.dividend = stripe_ff;
            div_req.divisor  = {{(rpsm_pkg::DIVS_W-rpsm_pkg::DISKS_W){1'b0}}, disks_ff};
            launched_in      = 1'b1;
            if (div_rsp.done) begin
               launched_in = 1'b0;
               pmod_in     = div_rsp.remainder[CW-1:0];
            end
         end
         rpsm_pkg::ST_DIV_BASE: begin
            // start minus offset is stripe * strip * data chunks, an exact division
            div_req.start    = !launched_ff;
            div_req.dividend = start_ff
                             - {{(rpsm_pkg::ADDR_W-rpsm_pkg::DIVS_W){1'b0}}, offset_ff};
            div_req.divisor  = {{(rpsm_pkg::DIVS_W-CW){1'b0}}, dc_ff};
            launched_in      = 1'b1;
            if (div_rsp.done) begin
               launched_in = 1'b0;
               dev_in      = {1'b0, cfg_dstart_ff} + {1'b0, div_rsp.quotient};
            end
         end
         rpsm_pkg::ST_MASK: begin
            parity_in = dc_ff - pmod_ff;
            bmap_in   = ones << first_ff;
            chunk_in  = first_ff;
            left_in   = nmod_ff[CW-1:0];
         end
         rpsm_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               o_dev_in     = dev_ff;
               o_bmap_in    = bmap_ff;
               o_status_in  = rpsm_pkg::STATUS_OK;
               if (left_ff != '0) begin
                  // data chunks skip over the parity disk
                  o_disk_in  = (chunk_ff < parity_ff) ? chunk_ff : chunk_ff + 1'b1;
                  o_chunk_in = chunk_ff;
                  o_par_in   = 1'b0;
                  o_last_in  = 1'b0;
                  chunk_in   = chunk_ff + 1'b1;
                  left_in    = left_ff - 1'b1;
               end else begin
                  o_disk_in  = parity_ff;
                  o_chunk_in = '0;
                  o_par_in   = 1'b1;
                  o_last_in  = 1'b1;
               end
            end
         end
         rpsm_pkg::ST_ERROR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               o_disk_in    = '0;
               o_dev_in     = '0;
               o_chunk_in   = '0;
               o_par_in     = 1'b0;
               o_bmap_in    = '0;
               o_status_in  = err_ff;
               o_last_in    = 1'b1;
            end
         end
         default: begin
            launched_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpsm_pkg::ST_IDLE;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff    <= start_in;
      count_ff    <= count_in;
      strip_ff    <= strip_in;
      disks_ff    <= disks_in;
      dc_ff       <= dc_in;
      sb_ff       <= sb_in;
      stripe_ff   <= stripe_in;
      offset_ff   <= offset_in;
      first_ff    <= first_in;
      nmod_ff     <= nmod_in;
      mis_ff      <= mis_in;
      pmod_ff     <= pmod_in;
      parity_ff   <= parity_in;
      dev_ff      <= dev_in;
      bmap_ff     <= bmap_in;
      chunk_ff    <= chunk_in;
      left_ff     <= left_in;
      err_ff      <= err_in;
      o_disk_ff   <= o_disk_in;
      o_dev_ff    <= o_dev_in;
      o_chunk_ff  <= o_chunk_in;
      o_par_ff    <= o_par_in;
      o_bmap_ff   <= o_bmap_in;
      o_status_ff <= o_status_in;
      o_last_ff   <= o_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rpsm_pkg::RSP_DATA_W - 2*CW - rpsm_pkg::DEV_W
                          - rpsm_pkg::BMAP_W){1'b0}},
                        o_bmap_ff, o_chunk_ff, o_dev_ff, o_disk_ff};
   assign rsp_tuser  = {o_status_ff, o_par_ff};
   assign rsp_tlast  = o_last_ff;

endmodule
`default_nettype wire

// ===== rtl/core/rpsm_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module rpsm_div (
   input  wire                 clock,
   input  wire                 reset,
   input  wire rpsm_pkg::div_req_type div_req,
   output rpsm_pkg::div_rsp_type div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [rpsm_pkg::STEP_W-1:0]   cnt_ff, cnt_in;
   logic [rpsm_pkg::DIVD_W-1:0]   q_ff, q_in;
   logic [rpsm_pkg::DIVS_W-1:0]   r_ff, r_in;
   logic [rpsm_pkg::DIVS_W-1:0]   d_ff, d_in;
   logic [rpsm_pkg::DIVS_W:0]     trial;
   logic [rpsm_pkg::DIVS_W:0]     diff;
   logic                          fits;

   assign trial = {r_ff, q_ff[rpsm_pkg::DIVD_W-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign fits  = trial >= {1'b0, d_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (div_req.start) begin
         // dividend arrives left aligned so steps bits sit at the top
         busy_in = 1'b1;
         cnt_in  = div_req.steps;
         q_in    = div_req.dividend;
         r_in    = '0;
         d_in    = div_req.divisor;
      end else if (busy_ff) begin
         q_in   = {q_ff[rpsm_pkg::DIVD_W-2:0], fits};
         r_in   = fits ? diff[rpsm_pkg::DIVS_W-1:0] : trial[rpsm_pkg::DIVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rpsm_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = q_ff;
   assign div_rsp.remainder = r_ff;

endmodule
`default_nettype wire
